// ----- design/hnhs_pkg.sv -----
package hnhs_pkg;

    localparam int MAG_W     = 64;
    localparam int CFG_W     = 8;
    localparam int CHOP_W    = 67;
    localparam int ROUND_W   = 64;
    localparam int LOW_KEEP  = 64;
    localparam int GAP_LIMIT = CHOP_W + ROUND_W + 2;
    localparam int GAP_W     = $clog2(GAP_LIMIT + 1);
    localparam int SUM_W     = CHOP_W + GAP_LIMIT + 1;
    localparam int EXP_W     = 14;
    localparam int LEN_IN_W  = 256;
    localparam int LEN_W     = 9;
    localparam int WORD_LO   = 62;
    localparam int WORD_HI   = 65;
    localparam int CUT_W     = 8;

    localparam int MC_LAT    = 5;
    localparam int ADD_LAT   = 5;
    localparam int FRONT_LAT = 2 * MC_LAT;
    localparam int CHAIN_LAT = 2 * (MC_LAT + ADD_LAT);
    localparam int PIPE_LAT  = FRONT_LAT + CHAIN_LAT;

    localparam logic signed [CFG_W-1:0] EXP_RESET = -8'sd66;

    localparam logic [3:0] Q_MINUS1   = 4'b1111;
    localparam logic [3:0] Q_MINUS2   = 4'b1110;
    localparam logic [2:0] FIRE_Q_MAX = 3'd4;

    // coefficient table slots
    localparam int ROM_NEG_LAST = 0;
    localparam int ROM_POS_LAST = 1;
    localparam int ROM_NEG_MID  = 2;
    localparam int ROM_POS_MID  = 3;
    localparam int ROM_NEG_LEAD = 4;
    localparam int ROM_POS_LEAD = 5;

    typedef logic signed [EXP_W-1:0] exp_t;
    typedef logic [LEN_IN_W-1:0] len_in_t;

    typedef struct packed {
        logic       near;
        logic [3:0] q;
        logic       lsb;
        logic       inc;
    } trace_t;

    typedef struct packed {
        logic             b65;
        logic [3:0]       word;
        logic [CUT_W-1:0] cut;
    } prod_info_t;

    typedef struct packed {
        trace_t     tr;
        prod_info_t info;
    } chain_ev_t;

    function automatic logic [CHOP_W-1:0] rom_sig(input int k);
        logic [CHOP_W-1:0] v;
        case (k)
            ROM_NEG_LAST: v = {3'd7, 64'hfffffffffffffffe};
            ROM_POS_LAST: v = {3'd5, 64'h5555555555554277};
            ROM_NEG_MID:  v = {3'd5, 64'hb05b05b05a18a1ba};
            ROM_POS_MID:  v = {3'd6, 64'h80680675b559f2cf};
            ROM_NEG_LEAD: v = {3'd4, 64'h9f93af61f5349300};
            ROM_POS_LEAD: v = {3'd4, 64'h7a4f2483514c1af8};
            default:      v = '0;
        endcase
        return v;
    endfunction

    function automatic exp_t rom_exp(input int k);
        exp_t v;
        case (k)
            ROM_NEG_LAST: v = -14'sd68;
            ROM_POS_LAST: v = -14'sd71;
            ROM_NEG_MID:  v = -14'sd76;
            ROM_POS_MID:  v = -14'sd82;
            ROM_NEG_LEAD: v = -14'sd88;
            ROM_POS_LEAD: v = -14'sd95;
            default:      v = '0;
        endcase
        return v;
    endfunction

    // position of the highest set bit plus one, zero for zero
    function automatic logic [LEN_W-1:0] bit_len(input len_in_t x);
        logic [LEN_W-1:0] len;
        len = '0;
        for (int i = 0; i < LEN_IN_W; i++)
        begin
            if (x[i])
            begin
                len = LEN_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

// ----- design/horner_near_half_scan.sv -----
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------------
// config   | cfg_we                | cfg_wdata: input_exponent (8 bit signed)
// input    | in_valid / in_ready   | magnitude_in
// output   | out_valid / out_ready | magnitude_echo, chain_is_positive, half_offset,
//          |                       | kept_lsb, rounds_up, prod_b65, fires,
//          |                       | prod_nibble, prod_excess, last_of_run
//
// One request enters per cycle while in_ready is high.
// Each multiply is split into four partial products over three stages, each
// normalize and each rounding add take two and five stages.
// An item with events on both chains holds the result register until both
// events have gone out, since both go through the one output port.
// rst_n clears all valid flags and loads input_exponent with -66.
// A stalled output holds the result register; empty stages keep filling.
module horner_near_half_scan (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hnhs_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hnhs_pkg::MAG_W-1:0]        magnitude_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hnhs_pkg::MAG_W-1:0]        magnitude_echo,
    output logic                              chain_is_positive,
    output logic signed [3:0]                 half_offset,
    output logic                              kept_lsb,
    output logic                              rounds_up,
    output logic                              prod_b65,
    output logic                              fires,
    output logic [3:0]                        prod_nibble,
    output logic [hnhs_pkg::CUT_W-1:0]        prod_excess,
    output logic                              last_of_run
);

    localparam int NS = hnhs_pkg::PIPE_LAT;
    localparam int FL = hnhs_pkg::FRONT_LAT;
    localparam int ML = hnhs_pkg::MC_LAT;
    localparam int CW = hnhs_pkg::CHOP_W;
    localparam int MW = hnhs_pkg::MAG_W;

    logic signed [hnhs_pkg::CFG_W-1:0] exp_reg;
    logic [NS-1:0]     vld_reg;
    logic [NS:0]       en;
    logic              res_vld_reg, neg_pend_reg, pos_pend_reg;
    hnhs_pkg::chain_ev_t neg_ev_reg, pos_ev_reg, neg_ev, pos_ev, sel_ev;
    logic [MW-1:0]     mag_res_reg, mag_d;
    logic              res_done, sel_pos;

    logic [CW-1:0]     sq_s, f_s;
    hnhs_pkg::exp_t    sq_e, f_e, m_e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= hnhs_pkg::EXP_RESET;
        end
        else if (cfg_we)
        begin
            exp_reg <= cfg_wdata;
        end
    end

    // stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[NS] = !res_vld_reg || res_done;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign m_e = hnhs_pkg::exp_t'(exp_reg);

    hnhs_mulchop #(.AW(MW), .BW(MW)) u_mc_sq (
        .clk      (clk),
        .stage_en (en[ML-1:0]),
        .a        (magnitude_in),
        .b        (magnitude_in),
        .e_sum    (m_e + m_e),
        .s_out    (sq_s),
        .e_out    (sq_e),
        .info     ()
    );

    hnhs_mulchop #(.AW(CW), .BW(CW)) u_mc_quad (
        .clk      (clk),
        .stage_en (en[FL-1:ML]),
        .a        (sq_s),
        .b        (sq_s),
        .e_sum    (sq_e + sq_e),
        .s_out    (f_s),
        .e_out    (f_e),
        .info     ()
    );

    hnhs_chain #(
        .LEAD_IDX (hnhs_pkg::ROM_NEG_LEAD),
        .MID_IDX  (hnhs_pkg::ROM_NEG_MID),
        .LAST_IDX (hnhs_pkg::ROM_NEG_LAST)
    ) u_chain_neg (
        .clk      (clk),
        .stage_en (en[NS-1:FL]),
        .f_s      (f_s),
        .f_e      (f_e),
        .ev       (neg_ev)
    );

    hnhs_chain #(
        .LEAD_IDX (hnhs_pkg::ROM_POS_LEAD),
        .MID_IDX  (hnhs_pkg::ROM_POS_MID),
        .LAST_IDX (hnhs_pkg::ROM_POS_LAST)
    ) u_chain_pos (
        .clk      (clk),
        .stage_en (en[NS-1:FL]),
        .f_s      (f_s),
        .f_e      (f_e),
        .ev       (pos_ev)
    );

    hnhs_delay #(.W(MW), .DEPTH(NS)) u_mag_dly (
        .clk      (clk),
        .stage_en (en[NS-1:0]),
        .d_in     (magnitude_in),
        .d_out    (mag_d)
    );

    // result register: negative chain event first, then positive
    always_comb
    begin
        sel_pos   = !neg_pend_reg;
        sel_ev    = sel_pos ? pos_ev_reg : neg_ev_reg;
        out_valid = res_vld_reg && (neg_pend_reg || pos_pend_reg);
        last_of_run = sel_pos || !pos_pend_reg;
        res_done  = !(neg_pend_reg || pos_pend_reg) || (out_ready && last_of_run);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg  <= 1'b0;
            neg_pend_reg <= 1'b0;
            pos_pend_reg <= 1'b0;
        end
        else if (en[NS])
        begin
            res_vld_reg  <= vld_reg[NS-1];
            neg_pend_reg <= vld_reg[NS-1] && neg_ev.tr.near;
            pos_pend_reg <= vld_reg[NS-1] && pos_ev.tr.near;
        end
        else if (out_valid && out_ready)
        begin
            // drop the negative event, the positive one follows
            neg_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS])
        begin
            neg_ev_reg  <= neg_ev;
            pos_ev_reg  <= pos_ev;
            mag_res_reg <= mag_d;
        end
    end

    assign magnitude_echo    = mag_res_reg;
    assign chain_is_positive = sel_pos;
    assign half_offset       = $signed(sel_ev.tr.q);
    assign kept_lsb          = sel_ev.tr.lsb;
    assign rounds_up         = sel_ev.tr.inc;
    assign prod_b65          = sel_ev.info.b65;
    assign prod_nibble       = sel_ev.info.word;
    assign prod_excess       = sel_ev.info.cut;
    assign fires = !sel_ev.tr.q[3] && (sel_ev.tr.q[2:0] <= hnhs_pkg::FIRE_Q_MAX)
                   && sel_ev.tr.inc && (sel_ev.tr.q[2] == sel_ev.info.b65);

    a_not_last_is_neg : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !chain_is_positive)
        else $error("non-final event is not from the negative chain");

    a_pos_follows_neg : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=>
            out_valid && chain_is_positive && last_of_run && $stable(magnitude_echo))
        else $error("positive event of the same request did not follow");

    a_fire_rounds_up : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fires |-> rounds_up && !half_offset[3])
        else $error("fire flag without round up or with negative offset");

endmodule

// ----- design/hnhs_delay.sv -----
module hnhs_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic [DEPTH-1:0] stage_en,
    input  logic [W-1:0]     d_in,
    output logic [W-1:0]     d_out
);

    logic [W-1:0] taps_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            taps_reg[0] <= d_in;
        end
    end

    for (genvar k = 1; k < DEPTH; k++)
    begin : g_tap
        always_ff @(posedge clk)
        begin
            if (stage_en[k])
            begin
                taps_reg[k] <= taps_reg[k-1];
            end
        end
    end

    assign d_out = taps_reg[DEPTH-1];

endmodule

// ----- design/hnhs_mulchop.sv -----
module hnhs_mulchop #(
    parameter int AW = hnhs_pkg::CHOP_W,
    parameter int BW = hnhs_pkg::CHOP_W
) (
    input  logic                               clk,
    input  logic [hnhs_pkg::MC_LAT-1:0]        stage_en,
    input  logic [AW-1:0]                      a,
    input  logic [BW-1:0]                      b,
    input  hnhs_pkg::exp_t                     e_sum,
    output logic [hnhs_pkg::CHOP_W-1:0]        s_out,
    output hnhs_pkg::exp_t                     e_out,
    output hnhs_pkg::prod_info_t               info
);

    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;
    localparam int CW = hnhs_pkg::CHOP_W;
    localparam int LK = hnhs_pkg::LOW_KEEP;
    localparam int LW = hnhs_pkg::LEN_W;

    logic [AL+BL-1:0] p00_reg;
    logic [AL+BH-1:0] p01_reg;
    logic [AH+BL-1:0] p10_reg;
    logic [AH+BH-1:0] p11_reg;
    hnhs_pkg::exp_t   e1_reg, e2_reg, e3_reg, e4_reg, e5_reg;
    logic [PW-1:0]    base_reg, cross_reg, prod_reg, prod4_reg;
    logic [LW-1:0]    len4_reg;
    logic [CW-1:0]    s_reg;
    hnhs_pkg::prod_info_t info_reg;

    logic signed [LW:0]   sh;
    logic [LW:0]          lamt;
    logic [PW-1:0]        shr;
    logic [CW-1:0]        low;
    logic [CW-1:0]        s_next;
    hnhs_pkg::prod_info_t info_next;

    always_comb
    begin
        sh   = $signed({1'b0, len4_reg}) - $signed((LW+1)'(CW));
        lamt = (LW+1)'(-sh);
        shr  = prod4_reg >> sh[LW-1:0];
        low  = {{(CW-LK){1'b0}}, prod4_reg[LK-1:0]};
        // short products keep only the low word, moved up to the top
        if (sh > 0)
        begin
            s_next = shr[CW-1:0];
        end
        else
        begin
            s_next = low << lamt;
        end
        info_next.b65  = prod4_reg[hnhs_pkg::WORD_HI];
        info_next.word = prod4_reg[hnhs_pkg::WORD_HI:hnhs_pkg::WORD_LO];
        info_next.cut  = sh[hnhs_pkg::CUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            p00_reg <= {{BL{1'b0}}, a[AL-1:0]}  * {{AL{1'b0}}, b[BL-1:0]};
            p01_reg <= {{BH{1'b0}}, a[AL-1:0]}  * {{AL{1'b0}}, b[BW-1:BL]};
            p10_reg <= {{BL{1'b0}}, a[AW-1:AL]} * {{AH{1'b0}}, b[BL-1:0]};
            p11_reg <= {{BH{1'b0}}, a[AW-1:AL]} * {{AH{1'b0}}, b[BW-1:BL]};
            e1_reg  <= e_sum;
        end
        if (stage_en[1])
        begin
            base_reg  <= {p11_reg, p00_reg};
            cross_reg <= (PW'(p01_reg) << BL) + (PW'(p10_reg) << AL);
            e2_reg    <= e1_reg;
        end
        if (stage_en[2])
        begin
            prod_reg <= base_reg + cross_reg;
            e3_reg   <= e2_reg;
        end
        if (stage_en[3])
        begin
            prod4_reg <= prod_reg;
            len4_reg  <= hnhs_pkg::bit_len(hnhs_pkg::len_in_t'(prod_reg));
            e4_reg    <= e3_reg;
        end
        if (stage_en[4])
        begin
            s_reg    <= s_next;
            e5_reg   <= e4_reg + hnhs_pkg::exp_t'(sh);
            info_reg <= info_next;
        end
    end

    assign s_out = s_reg;
    assign e_out = e5_reg;
    assign info  = info_reg;

endmodule

// ----- design/hnhs_rnadd.sv -----
module hnhs_rnadd (
    input  logic                           clk,
    input  logic [hnhs_pkg::ADD_LAT-1:0]   stage_en,
    input  logic [hnhs_pkg::CHOP_W-1:0]    x_s,
    input  hnhs_pkg::exp_t                 x_e,
    input  logic [hnhs_pkg::CHOP_W-1:0]    y_s,
    input  hnhs_pkg::exp_t                 y_e,
    output logic [hnhs_pkg::ROUND_W-1:0]   r_s,
    output hnhs_pkg::exp_t                 r_e,
    output hnhs_pkg::trace_t               tr
);

    localparam int CW = hnhs_pkg::CHOP_W;
    localparam int RW = hnhs_pkg::ROUND_W;
    localparam int SW = hnhs_pkg::SUM_W;
    localparam int EW = hnhs_pkg::EXP_W;
    localparam int GW = hnhs_pkg::GAP_W;
    localparam int LW = hnhs_pkg::LEN_W;
    localparam logic signed [EW:0] GAP_S = (EW+1)'(hnhs_pkg::GAP_LIMIT);

    // stage 1: order by exponent
    logic [CW-1:0]      hi_s, lo_s;
    hnhs_pkg::exp_t     hi_e, lo_e;
    logic signed [EW:0] diff;
    logic [GW-1:0]      gap_next;
    hnhs_pkg::exp_t     sc_next;

    logic [CW-1:0]  hi_s1_reg, lo_s1_reg;
    logic [GW-1:0]  gap1_reg;
    hnhs_pkg::exp_t sc1_reg, sc2_reg, sc3_reg, sc4_reg;

    logic [SW-1:0]  sum2_reg, sum3_reg;
    logic [LW-1:0]  len3_reg;

    // stage 4 signals
    logic signed [LW:0] sh;
    logic [LW-1:0]      shu, shm1;
    logic [LW:0]        lamt;
    logic [SW-1:0]      mask, low, inv, shr, top_shr;
    logic [RW-1:0]      sig_next;

    logic               pos4_reg, top4_reg;
    logic               lowhi_nz4_reg, lownz4_reg, invhi_nz4_reg, inv04_reg;
    logic [2:0]         lowlo4_reg;
    logic [RW-1:0]      sig4_reg;
    logic signed [LW:0] sh4_reg;

    // stage 5 signals
    hnhs_pkg::trace_t tr_next;
    logic [RW:0]      rsum;
    logic [RW-1:0]    rs_next;
    logic             carry;

    logic [RW-1:0]    rs_reg;
    hnhs_pkg::exp_t   re_reg;
    hnhs_pkg::trace_t tr_reg;

    always_comb
    begin
        if (x_e >= y_e)
        begin
            hi_s = x_s;
            hi_e = x_e;
            lo_s = y_s;
            lo_e = y_e;
        end
        else
        begin
            hi_s = y_s;
            hi_e = y_e;
            lo_s = x_s;
            lo_e = x_e;
        end
        diff = {hi_e[EW-1], hi_e} - {lo_e[EW-1], lo_e};
        if (hi_s == '0)
        begin
            gap_next = '0;
            sc_next  = lo_e;
        end
        else if (diff > GAP_S)
        begin
            // past this gap the low operand only acts as a sticky bit
            gap_next = GW'(hnhs_pkg::GAP_LIMIT);
            sc_next  = hi_e - EW'(hnhs_pkg::GAP_LIMIT);
        end
        else
        begin
            gap_next = diff[GW-1:0];
            sc_next  = lo_e;
        end
    end

    always_comb
    begin
        sh       = $signed({1'b0, len3_reg}) - $signed((LW+1)'(RW));
        shu      = sh[LW-1:0];
        shm1     = shu - LW'(1);
        lamt     = (LW+1)'(-sh);
        shr      = sum3_reg >> shu;
        top_shr  = sum3_reg >> shm1;
        mask     = ~({SW{1'b1}} << shm1);
        low      = sum3_reg & mask;
        inv      = ~sum3_reg & mask;
        if (sh > 0)
        begin
            sig_next = shr[RW-1:0];
        end
        else
        begin
            sig_next = RW'(sum3_reg << lamt);
        end
    end

    always_comb
    begin
        tr_next = '0;
        if (pos4_reg)
        begin
            tr_next.lsb = sig4_reg[0];
            if (top4_reg)
            begin
                tr_next.near = !lowhi_nz4_reg;
                tr_next.q    = lowhi_nz4_reg ? 4'd0 : {1'b0, lowlo4_reg};
                tr_next.inc  = lownz4_reg || sig4_reg[0];
            end
            else
            begin
                tr_next.near = !invhi_nz4_reg;
                if (!invhi_nz4_reg)
                begin
                    tr_next.q = inv04_reg ? hnhs_pkg::Q_MINUS2 : hnhs_pkg::Q_MINUS1;
                end
            end
        end
        rsum  = {1'b0, sig4_reg} + (RW+1)'(tr_next.inc);
        carry = rsum[RW];
        // renormalize when the increment carries out of the top
        rs_next = carry ? rsum[RW:1] : rsum[RW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            hi_s1_reg <= hi_s;
            lo_s1_reg <= lo_s;
            gap1_reg  <= gap_next;
            sc1_reg   <= sc_next;
        end
        if (stage_en[1])
        begin
            sum2_reg <= (SW'(hi_s1_reg) << gap1_reg) + SW'(lo_s1_reg);
            sc2_reg  <= sc1_reg;
        end
        if (stage_en[2])
        begin
            sum3_reg <= sum2_reg;
            len3_reg <= hnhs_pkg::bit_len(hnhs_pkg::len_in_t'(sum2_reg));
            sc3_reg  <= sc2_reg;
        end
        if (stage_en[3])
        begin
            pos4_reg      <= (sh > 0);
            top4_reg      <= top_shr[0];
            lowhi_nz4_reg <= |low[SW-1:3];
            lowlo4_reg    <= low[2:0];
            lownz4_reg    <= |low;
            invhi_nz4_reg <= |inv[SW-1:1];
            inv04_reg     <= inv[0];
            sig4_reg      <= sig_next;
            sh4_reg       <= sh;
            sc4_reg       <= sc3_reg;
        end
        if (stage_en[4])
        begin
            rs_reg <= rs_next;
            re_reg <= sc4_reg + hnhs_pkg::exp_t'(sh4_reg) + EW'(carry);
            tr_reg <= tr_next;
        end
    end

    assign r_s = rs_reg;
    assign r_e = re_reg;
    assign tr  = tr_reg;

endmodule

// ----- design/hnhs_chain.sv -----
module hnhs_chain #(
    parameter int LEAD_IDX = hnhs_pkg::ROM_NEG_LEAD,
    parameter int MID_IDX  = hnhs_pkg::ROM_NEG_MID,
    parameter int LAST_IDX = hnhs_pkg::ROM_NEG_LAST
) (
    input  logic                             clk,
    input  logic [hnhs_pkg::CHAIN_LAT-1:0]   stage_en,
    input  logic [hnhs_pkg::CHOP_W-1:0]      f_s,
    input  hnhs_pkg::exp_t                   f_e,
    output hnhs_pkg::chain_ev_t              ev
);

    localparam int CW = hnhs_pkg::CHOP_W;
    localparam int RW = hnhs_pkg::ROUND_W;
    localparam int EW = hnhs_pkg::EXP_W;
    localparam int ML = hnhs_pkg::MC_LAT;
    localparam int AL = hnhs_pkg::ADD_LAT;
    localparam int IW = $bits(hnhs_pkg::prod_info_t);

    logic [CW-1:0]        t1_s, t2_s, fd_s;
    hnhs_pkg::exp_t       t1_e, t2_e, fd_e, a1_e;
    logic [RW-1:0]        a1_s;
    logic [CW+EW-1:0]     fd_bits;
    hnhs_pkg::prod_info_t info2;
    logic [IW-1:0]        info_d;
    hnhs_pkg::trace_t     tr_last;

    hnhs_mulchop #(.AW(CW), .BW(CW)) u_mc_lead (
        .clk      (clk),
        .stage_en (stage_en[ML-1:0]),
        .a        (f_s),
        .b        (hnhs_pkg::rom_sig(LEAD_IDX)),
        .e_sum    (f_e + hnhs_pkg::rom_exp(LEAD_IDX)),
        .s_out    (t1_s),
        .e_out    (t1_e),
        .info     ()
    );

    hnhs_rnadd u_add_mid (
        .clk      (clk),
        .stage_en (stage_en[ML+AL-1:ML]),
        .x_s      (hnhs_pkg::rom_sig(MID_IDX)),
        .x_e      (hnhs_pkg::rom_exp(MID_IDX)),
        .y_s      (t1_s),
        .y_e      (t1_e),
        .r_s      (a1_s),
        .r_e      (a1_e),
        .tr       ()
    );

    // hold the fourth power until the middle term is ready
    hnhs_delay #(.W(CW + EW), .DEPTH(ML + AL)) u_f_dly (
        .clk      (clk),
        .stage_en (stage_en[ML+AL-1:0]),
        .d_in     ({f_s, f_e}),
        .d_out    (fd_bits)
    );

    assign fd_s = fd_bits[CW+EW-1:EW];
    assign fd_e = fd_bits[EW-1:0];

    hnhs_mulchop #(.AW(CW), .BW(RW)) u_mc_a1 (
        .clk      (clk),
        .stage_en (stage_en[2*ML+AL-1:ML+AL]),
        .a        (fd_s),
        .b        (a1_s),
        .e_sum    (fd_e + a1_e),
        .s_out    (t2_s),
        .e_out    (t2_e),
        .info     (info2)
    );

    hnhs_rnadd u_add_last (
        .clk      (clk),
        .stage_en (stage_en[2*ML+2*AL-1:2*ML+AL]),
        .x_s      (hnhs_pkg::rom_sig(LAST_IDX)),
        .x_e      (hnhs_pkg::rom_exp(LAST_IDX)),
        .y_s      (t2_s),
        .y_e      (t2_e),
        .r_s      (),
        .r_e      (),
        .tr       (tr_last)
    );

    hnhs_delay #(.W(IW), .DEPTH(AL)) u_info_dly (
        .clk      (clk),
        .stage_en (stage_en[2*ML+2*AL-1:2*ML+AL]),
        .d_in     (info2),
        .d_out    (info_d)
    );

    assign ev = {tr_last, info_d};

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int CHOP       = 67;
    localparam int RWIDTH     = 64;
    localparam int GAP_MAX    = CHOP + RWIDTH + 2;
    localparam int DRAIN_WAIT = 48;
    localparam int CYCLE_CAP  = 600000;
    localparam int PRINT_CAP  = 40;

    localparam int SLOT_NEG_LAST = 0;
    localparam int SLOT_POS_LAST = 1;
    localparam int SLOT_NEG_MID  = 2;
    localparam int SLOT_POS_MID  = 3;
    localparam int SLOT_NEG_LEAD = 4;
    localparam int SLOT_POS_LEAD = 5;

    typedef struct {
        int           e;
        logic [255:0] s;
    } fnum_t;

    typedef struct {
        fnum_t r;
        int    q;
        logic  lsb;
        logic  inc;
        logic  near;
    } round_trace_t;

    typedef struct packed {
        logic [63:0] mag;
        logic        pos;
        logic [3:0]  off;
        logic        lsb;
        logic        inc;
        logic        b65;
        logic        fire;
        logic [3:0]  word;
        logic [7:0]  cut;
        logic        last;
    } near_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] magnitude_in = 64'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] magnitude_echo;
    logic        chain_is_positive;
    logic signed [3:0] half_offset;
    logic        kept_lsb;
    logic        rounds_up;
    logic        prod_b65;
    logic        fires;
    logic [3:0]  prod_nibble;
    logic [7:0]  prod_excess;
    logic        last_of_run;

    logic [63:0]   pending_mag[$];
    near_event_t   event_q[$];
    int            errors = 0;
    int            cycles = 0;
    int            accepted = 0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;
    logic [15:0]   stall_pat = 16'hffff;
    logic signed [7:0] exp_now = -8'sd66;

    horner_near_half_scan DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .magnitude_in(magnitude_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .magnitude_echo(magnitude_echo), .chain_is_positive(chain_is_positive),
        .half_offset(half_offset), .kept_lsb(kept_lsb),
        .rounds_up(rounds_up), .prod_b65(prod_b65), .fires(fires),
        .prod_nibble(prod_nibble), .prod_excess(prod_excess),
        .last_of_run(last_of_run)
    );

    always #5 clk = ~clk;

    function automatic fnum_t coef(input int k);
        fnum_t c;
        c.s = '0;
        case (k)
            SLOT_NEG_LAST: begin c.s[66:0] = {3'd7, 64'hfffffffffffffffe}; c.e = -68; end
            SLOT_POS_LAST: begin c.s[66:0] = {3'd5, 64'h5555555555554277}; c.e = -71; end
            SLOT_NEG_MID:  begin c.s[66:0] = {3'd5, 64'hb05b05b05a18a1ba}; c.e = -76; end
            SLOT_POS_MID:  begin c.s[66:0] = {3'd6, 64'h80680675b559f2cf}; c.e = -82; end
            SLOT_NEG_LEAD: begin c.s[66:0] = {3'd4, 64'h9f93af61f5349300}; c.e = -88; end
            default:       begin c.s[66:0] = {3'd4, 64'h7a4f2483514c1af8}; c.e = -95; end
        endcase
        return c;
    endfunction

    function automatic int width_of(input logic [255:0] x);
        for (int i = 255; i >= 0; i--)
        begin
            if (x[i])
                return i + 1;
        end
        return 0;
    endfunction

    function automatic fnum_t chopped_mul(input fnum_t a, input fnum_t b);
        logic [255:0] p;
        fnum_t r;
        int sh;
        p = a.s * b.s;
        sh = width_of(p) - CHOP;
        if (sh > 0)
            r.s = p >> sh;
        else
            r.s = {192'd0, p[63:0]} << (-sh);
        r.e = a.e + b.e + sh;
        return r;
    endfunction

    function automatic round_trace_t round_add(input fnum_t x, input fnum_t y);
        round_trace_t t;
        fnum_t hi, lo;
        int gap, scale, sh;
        logic [255:0] s, ret, mask, low, inv;
        t.q = 0; t.lsb = 0; t.inc = 0; t.near = 0;
        if (x.e >= y.e) begin hi = x; lo = y; end
        else begin hi = y; lo = x; end
        gap = hi.e - lo.e;
        scale = lo.e;
        if (hi.s == '0)
            gap = 0;
        else if (gap > GAP_MAX)
        begin
            gap = GAP_MAX;
            scale = hi.e - GAP_MAX;
        end
        s = (hi.s << gap) + lo.s;
        sh = width_of(s) - RWIDTH;
        if (sh <= 0)
        begin
            t.r.s = s << (-sh);
            t.r.e = scale + sh;
            return t;
        end
        ret = s >> sh;
        t.lsb = ret[0];
        mask = (256'd1 << (sh - 1)) - 256'd1;
        low = s & mask;
        if (s[sh-1])
        begin
            if (low <= 256'd7)
            begin
                t.q = int'(low[3:0]);
                t.near = 1'b1;
            end
            t.inc = (low != '0) || t.lsb;
        end
        else
        begin
            inv = ~s & mask;
            if (inv <= 256'd1)
            begin
                t.q = -(int'(inv[1:0]) + 1);
                t.near = 1'b1;
            end
        end
        if (t.inc)
        begin
            ret = ret + 256'd1;
            if (width_of(ret) > RWIDTH)
            begin
                ret = ret >> 1;
                sh++;
            end
        end
        t.r.s = ret;
        t.r.e = scale + sh;
        return t;
    endfunction

    function automatic bit chain_event(input logic [63:0] m, input logic pos,
                                       input fnum_t f, input int lead,
                                       input int mid, input int lst,
                                       output near_event_t ev);
        round_trace_t a1, t;
        logic [255:0] p;
        int cut;
        a1 = round_add(coef(mid), chopped_mul(f, coef(lead)));
        t = round_add(coef(lst), chopped_mul(f, a1.r));
        ev = '0;
        if (!t.near)
            return 1'b0;
        p = f.s * a1.r.s;
        cut = width_of(p) - CHOP;
        ev.mag  = m;
        ev.pos  = pos;
        ev.off  = t.q[3:0];
        ev.lsb  = t.lsb;
        ev.inc  = t.inc;
        ev.b65  = p[65];
        ev.fire = (t.q >= 0) && (t.q <= 4) && t.inc && (t.q[2] == p[65]);
        ev.word = p[65:62];
        ev.cut  = cut[7:0];
        ev.last = 1'b0;
        return 1'b1;
    endfunction

    // returns how many near-half events the magnitude raises, in output order
    function automatic int scan_events(input logic [63:0] m, input logic signed [7:0] ex,
                                       output near_event_t ev0, output near_event_t ev1);
        fnum_t mg, sq, f;
        near_event_t en, ep;
        bit hn, hp;
        int n;
        mg.s = '0;
        mg.s[63:0] = m;
        mg.e = int'(ex);
        sq = chopped_mul(mg, mg);
        f = chopped_mul(sq, sq);
        hn = chain_event(m, 1'b0, f, SLOT_NEG_LEAD, SLOT_NEG_MID, SLOT_NEG_LAST, en);
        hp = chain_event(m, 1'b1, f, SLOT_POS_LEAD, SLOT_POS_MID, SLOT_POS_LAST, ep);
        ev0 = '0;
        ev1 = '0;
        n = 0;
        if (hn) begin ev0 = en; n = 1; end
        if (hp)
        begin
            if (n == 0) ev0 = ep;
            else ev1 = ep;
            n++;
        end
        if (n == 1) ev0.last = 1'b1;
        if (n == 2) ev1.last = 1'b1;
        return n;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch %s: got %h, expected %h (cycle %0d)", what, got, want, cycles);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // request driver: bursts separated by random gaps
    always @(posedge clk)
    begin
        near_event_t e0, e1;
        int n;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                n = scan_events(magnitude_in, exp_now, e0, e1);
                if (n > 0) event_q.push_back(e0);
                if (n > 1) event_q.push_back(e1);
                accepted <= accepted + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_mag.size() > 0)
                begin
                    in_valid <= 1'b1;
                    magnitude_in <= pending_mag.pop_front();
                    if (burst_left > 1)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, plus one long hold to back up the pipeline
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!hold_done && accepted >= 300)
            begin
                hold_done <= 1'b1;
                hold_left <= 400;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= stall_pat[cycles % 16];
                if (cycles % 256 == 0)
                    stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
            end
        end
    end

    always @(posedge clk)
    begin
        near_event_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (event_q.size() == 0)
                report("unexpected result", magnitude_echo, 64'd0);
            else
            begin
                w = event_q.pop_front();
                if (magnitude_echo !== w.mag)
                    report("magnitude_echo", magnitude_echo, w.mag);
                if (chain_is_positive !== w.pos)
                    report("chain_is_positive", 64'(chain_is_positive), 64'(w.pos));
                if (half_offset !== w.off)
                    report("half_offset", 64'($unsigned(half_offset)), 64'(w.off));
                if (kept_lsb !== w.lsb)
                    report("kept_lsb", 64'(kept_lsb), 64'(w.lsb));
                if (rounds_up !== w.inc)
                    report("rounds_up", 64'(rounds_up), 64'(w.inc));
                if (prod_b65 !== w.b65)
                    report("prod_b65", 64'(prod_b65), 64'(w.b65));
                if (fires !== w.fire)
                    report("fires", 64'(fires), 64'(w.fire));
                if (prod_nibble !== w.word)
                    report("prod_nibble", 64'(prod_nibble), 64'(w.word));
                if (prod_excess !== w.cut)
                    report("prod_excess", 64'(prod_excess), 64'(w.cut));
                if (last_of_run !== w.last)
                    report("last_of_run", 64'(last_of_run), 64'(w.last));
            end
        end
    end

    function automatic logic [63:0] pick_magnitude();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 255));
            2: return 64'd1 << $urandom_range(0, 63);
            3: return ~64'd0 >> $urandom_range(0, 63);
            4: return {1'b1, 31'($urandom), $urandom};
            default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_item(input logic [63:0] m);
        pending_mag.push_back(m);
    endtask

    // favor magnitudes that raise events, since they are sparse
    task automatic queue_random(input int count);
        near_event_t e0, e1;
        logic [63:0] m;
        for (int i = 0; i < count; i++)
        begin
            m = pick_magnitude();
            if ($urandom_range(0, 2) == 0)
            begin
                for (int k = 0; k < 12; k++)
                begin
                    if (scan_events(m, exp_now, e0, e1) > 0)
                        break;
                    m = pick_magnitude();
                end
            end
            queue_item(m);
        end
    endtask

    task automatic drain();
        while (pending_mag.size() > 0 || in_valid || event_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_exponent(input logic signed [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        exp_now = v;
    endtask

    initial
    begin
        logic signed [7:0] exps[6];
        exps = '{8'sd0, -8'sd128, -8'sd66, -8'sd1, -8'sd100, -8'sd66};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and zero under the reset exponent
        queue_item(64'd0);
        queue_item(64'd1);
        queue_item(64'd2);
        queue_item(64'd3);
        queue_item(~64'd0);
        queue_item(64'h8000000000000000);
        queue_item(64'h7fffffffffffffff);
        queue_item(64'haaaaaaaaaaaaaaaa);
        queue_item(64'h5555555555555555);
        queue_item(64'h00000000ffffffff);
        queue_item(64'hffffffff00000000);
        queue_item(64'hb504f333f9de6484);
        queue_item(64'hc000000000000000);
        queue_item(64'h0000000100000000);
        queue_random(70);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 4)
                write_exponent(-8'sd128 + 8'($urandom_range(0, 128)));
            else
                write_exponent(exps[ph]);
            if (ph < 2)
            begin
                queue_item(64'd0);
                queue_item(~64'd0);
                queue_item(64'd1);
            end
            queue_random(110);
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
